/* design/pumqm_pkg.sv */
// Package for the per-user memory quota monitor: item types, codes and sizes.
// No dependencies; every design file imports it.
package pumqm_pkg;

    // Default store sizes
    localparam int PROCESS_SLOTS_DEF = 1024;
    localparam int MEMBERS_DEF       = 2;
    localparam int USER_SLOTS_DEF    = 128;

    // Field widths
    localparam int SIZE_W   = 32;
    localparam int TOTAL_W  = 40;
    localparam int COUNT_W  = 8;
    localparam int PERIOD_W = 8;

    localparam logic [PERIOD_W-1:0] CHECK_PERIOD_RST = 8'd11;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX        = 40'hFF_FFFF_FFFF;
    localparam logic [COUNT_W-1:0]  COUNT_MAX        = 8'd255;

    // ceil(2^35 / 10): floor(x / 10) == (x * RECIP_TENTH) >> 35 for any 32-bit x
    localparam logic [31:0] RECIP_TENTH = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Item kinds
    localparam logic ACT_SIZE  = 1'b0;
    localparam logic ACT_LIMIT = 1'b1;

    typedef struct packed {
        logic               action;
        logic [9:0]         process_slot;
        logic               member;
        logic [6:0]         user_slot;
        logic [SIZE_W-1:0]  amount;
    } pumqm_in_t;

    typedef struct packed {
        logic               kill_now;
        logic               periodic_kill;
        logic [COUNT_W-1:0] over_users;
        logic [TOTAL_W-1:0] user_total;
    } pumqm_out_t;

endpackage

/* design/per_user_memory_quota_monitor.sv */
// Top level of the per-user memory quota monitor.
// Depends on pumqm_pkg (item types, widths, codes).

// For each item the accept edge reads the process-size memory and
// the user memory (limit and total in one word), and the compute edge then
// computes the new total, checks the soft limit and writes the memories back. A stalled
// output holds the block in the compute state. A limit load stores
// floor(amount*9/10) with one 32x32 reciprocal multiply at the accept edge.
// After reset a clearing pass zeroes both memories, one address per cycle, over
// max(PROCESS_SLOTS*MEMBERS, USER_SLOTS) addresses (2048 with the defaults); no
// item is taken in that time, while check_period writes are always accepted.
module per_user_memory_quota_monitor #(
    parameter int PROCESS_SLOTS = pumqm_pkg::PROCESS_SLOTS_DEF,
    parameter int MEMBERS       = pumqm_pkg::MEMBERS_DEF,
    parameter int USER_SLOTS    = pumqm_pkg::USER_SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  pumqm_pkg::pumqm_in_t   in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output pumqm_pkg::pumqm_out_t  out_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [pumqm_pkg::PERIOD_W-1:0] cfg_data
);
    import pumqm_pkg::*;

    localparam int PD    = PROCESS_SLOTS * MEMBERS;
    localparam int PIW   = (PD > 1) ? $clog2(PD) : 1;
    localparam int UIW   = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
    localparam int CLR_N = (PD > USER_SLOTS) ? PD : USER_SLOTS;
    localparam int CW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam int UMW   = SIZE_W + TOTAL_W;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_CALC  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       clr_reg, clr_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [PERIOD_W-1:0] event_reg, event_next;
    logic                out_valid_reg, out_valid_next;
    pumqm_out_t          out_reg, out_next;

    // Payload registers of the item at work
    pumqm_in_t           item_reg;
    logic [PIW-1:0]      pidx_reg;
    logic [63:0]         prod_reg;

    // Memories and their registered read data
    logic [SIZE_W-1:0]   pmem [PD];
    logic [UMW-1:0]      umem [USER_SLOTS];
    logic [SIZE_W-1:0]   prd_reg;
    logic [UMW-1:0]      urd_reg;

    logic                in_accept;
    logic                calc_go;
    logic                clearing;
    logic                proc_ok;
    logic                user_ok;
    logic [PIW-1:0]      pidx_in;
    logic [UIW-1:0]      uidx_in;
    logic [UIW-1:0]      uidx;

    logic                pwe;
    logic [PIW-1:0]      pwa;
    logic [SIZE_W-1:0]   pwd;
    logic                uwe;
    logic [UIW-1:0]      uwa;
    logic [UMW-1:0]      uwd;

    logic [TOTAL_W-1:0]  prev_total;
    logic [SIZE_W-1:0]   lim;
    logic [SIZE_W-1:0]   amt_eff;
    logic [SIZE_W-1:0]   old_eff;
    logic signed [41:0]  sum;
    logic [TOTAL_W-1:0]  next_total;
    logic [TOTAL_W-1:0]  lim_ext;
    logic                cross_up;
    logic                cross_down;
    logic [PERIOD_W-1:0] event_inc;
    logic                check_hit;

    logic [SIZE_W-1:0]   quot;
    logic [SIZE_W-1:0]   tenq;
    logic [SIZE_W-1:0]   lim_new;

    // Handshakes
    assign clearing  = (state_reg == ST_CLEAR);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign calc_go   = (state_reg == ST_CALC) && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Address the stores from the incoming item
    assign pidx_in = PIW'(32'(in_item.process_slot) * 32'(MEMBERS) + 32'(in_item.member));
    assign uidx_in = UIW'(in_item.user_slot);
    assign uidx    = UIW'(item_reg.user_slot);

    // Range checks of the item at work
    assign proc_ok = (32'(item_reg.process_slot) < 32'(PROCESS_SLOTS))
                  && (32'(item_reg.member) < 32'(MEMBERS));
    assign user_ok = 32'(item_reg.user_slot) < 32'(USER_SLOTS);

    // Soft limit: floor(9a/10) = a - ceil(a/10)
    assign quot    = 32'(prod_reg[63:RECIP_SHIFT]);
    assign tenq    = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
    assign lim_new = item_reg.amount - quot - 32'(item_reg.amount != tenq);

    // New user total, clamped to the range of the store
    assign prev_total = urd_reg[TOTAL_W-1:0];
    assign lim        = urd_reg[UMW-1:TOTAL_W];
    assign amt_eff    = proc_ok ? item_reg.amount : '0;
    assign old_eff    = proc_ok ? prd_reg : '0;
    assign sum        = $signed({2'b00, prev_total}) + $signed({10'd0, amt_eff})
                      - $signed({10'd0, old_eff});

    always_comb
    begin
        if (sum[41])
            next_total = '0;
        else if (sum[40])
            next_total = TOTAL_MAX;
        else
            next_total = sum[TOTAL_W-1:0];
    end

    // Soft-limit crossings
    assign lim_ext    = TOTAL_W'(lim);
    assign cross_up   = user_ok && (lim != '0) && (prev_total <= lim_ext)
                     && (next_total > lim_ext);
    assign cross_down = user_ok && (lim != '0) && (prev_total > lim_ext)
                     && (next_total <= lim_ext);

    // Periodic check counter
    assign event_inc = event_reg + 8'd1;
    assign check_hit = (event_inc >= period_reg);

    // Memory write ports: clearing pass, else write-back of the item at work
    always_comb
    begin
        if (clearing)
        begin
            pwe = 32'(clr_reg) < 32'(PD);
            pwa = PIW'(clr_reg);
            pwd = '0;
            uwe = 32'(clr_reg) < 32'(USER_SLOTS);
            uwa = UIW'(clr_reg);
            uwd = '0;
        end
        else
        begin
            pwe = calc_go && (item_reg.action == ACT_SIZE) && proc_ok;
            pwa = pidx_reg;
            pwd = item_reg.amount;
            uwe = calc_go && user_ok;
            uwa = uidx;
            if (item_reg.action == ACT_LIMIT)
                uwd = {lim_new, prev_total};
            else
                uwd = {lim, next_total};
        end
    end

    // Sequence, counters and result
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        period_next    = period_reg;
        count_next     = count_reg;
        event_next     = event_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (cfg_valid && cfg_ready)
            period_next = cfg_data;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + CW'(1);
                if (clr_reg == CW'(CLR_N - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (calc_go)
                begin
                    state_next             = ST_IDLE;
                    out_valid_next         = 1'b1;
                    out_next.kill_now      = 1'b0;
                    out_next.periodic_kill = 1'b0;
                    out_next.user_total    = user_ok ? prev_total : '0;
                    if (item_reg.action == ACT_SIZE)
                    begin
                        if (cross_up && count_reg != COUNT_MAX)
                            count_next = count_reg + 8'd1;
                        else if (cross_down && count_reg != '0)
                            count_next = count_reg - 8'd1;
                        out_next.kill_now   = cross_up;
                        out_next.user_total = user_ok ? next_total : '0;
                        if (check_hit)
                        begin
                            event_next             = '0;
                            out_next.periodic_kill = (count_next != '0);
                        end
                        else
                            event_next = event_inc;
                    end
                    out_next.over_users = count_next;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            period_reg    <= CHECK_PERIOD_RST;
            count_reg     <= '0;
            event_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            period_reg    <= period_next;
            count_reg     <= count_next;
            event_reg     <= event_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold the item and its reciprocal product
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (in_accept)
        begin
            item_reg <= in_item;
            pidx_reg <= pidx_in;
            prod_reg <= 64'(in_item.amount) * 64'(RECIP_TENTH);
        end
    end

    // Process-size memory
    always_ff @(posedge clk)
    begin
        if (pwe)
            pmem[pwa] <= pwd;
        if (in_accept)
            prd_reg <= pmem[pidx_in];
    end

    // User memory: soft limit over running total
    always_ff @(posedge clk)
    begin
        if (uwe)
            umem[uwa] <= uwd;
        if (in_accept)
            urd_reg <= umem[uidx_in];
    end

    // A kill request always comes with a nonzero over-limit count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kill_now |-> out_item.over_users != '0)
        else $error("kill_now with zero over_users");

    // A periodic kill is only raised while some user is over its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.periodic_kill |-> out_item.over_users != '0)
        else $error("periodic_kill with zero over_users");

    // A new result appears only right after the compute cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_CALC))
        else $error("result raised outside compute cycle");

    // The over-limit count moves only when an item completes
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(calc_go))
        else $error("over-limit count changed without an item");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

endmodule
